FILE: sv/xmbd_pkg.sv
// ----------------------------------------------------------------------------
// xmbd_pkg: shared types and constants of the XOR-mask block deinterleaver
// Register indexes, reset values, the configuration bundle and the result
// bundle that passes from the decode core to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package xmbd_pkg;

  // Default width of the message byte counters
  localparam int unsigned XMBD_POS_BITS = 24;

  // Fixed field widths
  localparam int unsigned XMBD_OUT_POS_W = 24;
  localparam int unsigned XMBD_CFG_W     = 24;
  localparam int unsigned XMBD_IDX_W     = 3;

  // Register indexes
  localparam logic [XMBD_IDX_W-1:0] XMBD_REG_MASK_START = 3'd0;
  localparam logic [XMBD_IDX_W-1:0] XMBD_REG_MASK_INC   = 3'd1;
  localparam logic [XMBD_IDX_W-1:0] XMBD_REG_BLOCK_SIZE = 3'd2;
  localparam logic [XMBD_IDX_W-1:0] XMBD_REG_DEC_LIMIT  = 3'd3;
  localparam logic [XMBD_IDX_W-1:0] XMBD_REG_MSG_LEN    = 3'd4;

  // Register reset values
  localparam logic [7:0]  XMBD_RST_MASK_START = 8'h1b;
  localparam logic [7:0]  XMBD_RST_MASK_INC   = 8'h37;
  localparam logic [15:0] XMBD_RST_BLOCK_SIZE = 16'd16;
  localparam logic [23:0] XMBD_RST_DEC_LIMIT  = 24'd16;
  localparam logic [23:0] XMBD_RST_MSG_LEN    = 24'd16;

  // Configuration registers as seen by the core
  typedef struct packed {
    logic [7:0]  mask_start;
    logic [7:0]  mask_increment;
    logic [15:0] block_size;
    logic [23:0] decode_limit;
    logic [23:0] message_length;
  } xmbd_cfg_t;

  // One result item
  typedef struct packed {
    logic [7:0]                plain_byte;
    logic [XMBD_OUT_POS_W-1:0] byte_position;
    logic                      last_of_message;
  } xmbd_result_t;

endpackage : xmbd_pkg

`default_nettype wire

FILE: sv/xmbd_core.sv
// ----------------------------------------------------------------------------
// xmbd_core: per-byte decode state and result logic
// Holds the running mask, byte counter, block bookkeeping and budget. For
// each transfer it decides block entry, forms the plaintext byte and its
// position, and advances the state in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xmbd_core
  import xmbd_pkg::*;
#(
  parameter int unsigned PosW = XMBD_POS_BITS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire xmbd_cfg_t    cfg_i,
  input  wire logic         accept_i,
  input  wire logic [7:0]   cipher_byte_i,
  input  wire logic         first_of_message_i,
  output xmbd_result_t      result_o
);

  localparam int unsigned CmpW = PosW + 24;
  localparam logic [PosW-1:0] PosOne = PosW'(1);
  localparam logic [PosW-1:0] PosTwo = PosW'(2);

  // State registers
  logic [7:0]      mask_q, mask_d;
  logic [PosW-1:0] taken_q, taken_d;
  logic [PosW-1:0] pos_q, pos_d;     // position of the next block byte
  logic [PosW-1:0] top_q, top_d;     // position of the first block byte
  logic [15:0]     len_q, len_d;
  logic [15:0]     off_q, off_d;
  logic [23:0]     limit_q, limit_d;
  logic            inside_q, inside_d;

  // State after an optional restart
  logic [7:0]      mask_eff;
  logic [PosW-1:0] t_eff;
  logic [23:0]     limit_eff;
  logic            inside_eff;

  // Block decision
  logic [23:0]     even_len;
  logic [CmpW-1:0] t_ext, even_ext, rest, bs_ext, top_ext;
  logic [15:0]     bs_eff, len_new;
  logic            start;

  // Current byte
  logic            in_blk;
  logic [15:0]     cur_len, cur_off, half_m1;
  logic [PosW-1:0] cur_pos, cur_top, pos_sel;
  logic            blk_end;
  logic [23:0]     msg_m1;
  logic [CmpW-1:0] msg_m1_ext, pos_ext;

  // Apply restart before the decision
  always_comb begin
    if (first_of_message_i) begin
      mask_eff   = cfg_i.mask_start;
      t_eff      = '0;
      limit_eff  = cfg_i.decode_limit;
      inside_eff = 1'b0;
    end else begin
      mask_eff   = mask_q;
      t_eff      = taken_q;
      limit_eff  = limit_q;
      inside_eff = inside_q;
    end
  end

  // Decide whether a new block opens at this byte
  always_comb begin
    even_len = {cfg_i.message_length[23:1], 1'b0};
    bs_eff   = {cfg_i.block_size[15:1], 1'b0};
    if (bs_eff == 16'd0) begin
      bs_eff = 16'd2;
    end
    t_ext    = {{24{1'b0}}, t_eff};
    even_ext = {{PosW{1'b0}}, even_len};
    bs_ext   = {{(CmpW-16){1'b0}}, bs_eff};
    rest     = even_ext - t_ext;
    start    = !inside_eff && (t_ext < even_ext) && (limit_eff != 24'd0);
    len_new  = (rest < bs_ext) ? rest[15:0] : bs_eff;
    top_ext  = t_ext + {{(CmpW-16){1'b0}}, len_new} - {{(CmpW-1){1'b0}}, 1'b1};
  end

  // Select the block bookkeeping for this byte; a one-byte block has no
  // first half, so its byte lands one below the block base
  always_comb begin
    in_blk  = inside_eff || start;
    cur_len = start ? len_new : len_q;
    cur_off = start ? 16'd0 : off_q;
    cur_top = start ? top_ext[PosW-1:0] : top_q;
    cur_pos = start ? ((len_new[15:1] == 15'd0) ? (top_ext[PosW-1:0] - PosOne)
                                                : top_ext[PosW-1:0])
                    : pos_q;
    half_m1 = {1'b0, cur_len[15:1]} - 16'd1;
    blk_end = (cur_off == cur_len - 16'd1);
    pos_sel = in_blk ? cur_pos : t_eff;
  end

  // Form the result
  always_comb begin
    msg_m1     = cfg_i.message_length - 24'd1;
    msg_m1_ext = {{PosW{1'b0}}, msg_m1};
    pos_ext    = {{24{1'b0}}, pos_sel};
    result_o.plain_byte      = in_blk ? (cipher_byte_i ^ mask_eff) : cipher_byte_i;
    result_o.byte_position   = pos_ext[XMBD_OUT_POS_W-1:0];
    result_o.last_of_message = (cfg_i.message_length != 24'd0) &&
                               (t_eff == msg_m1_ext[PosW-1:0]);
  end

  // Advance the state on every transfer
  always_comb begin
    mask_d   = mask_q;
    taken_d  = taken_q;
    pos_d    = pos_q;
    top_d    = top_q;
    len_d    = len_q;
    off_d    = off_q;
    limit_d  = limit_q;
    inside_d = inside_q;
    if (accept_i) begin
      taken_d  = t_eff + PosOne;
      limit_d  = limit_eff;
      mask_d   = mask_eff;
      inside_d = 1'b0;
      if (start) begin
        limit_d = (limit_eff > {8'd0, len_new}) ? (limit_eff - {8'd0, len_new}) : 24'd0;
      end
      if (in_blk) begin
        mask_d   = mask_eff + cfg_i.mask_increment;
        len_d    = cur_len;
        top_d    = cur_top;
        off_d    = cur_off + 16'd1;
        inside_d = !blk_end;
        pos_d    = (cur_off == half_m1) ? (cur_top - PosOne) : (cur_pos - PosTwo);
      end
    end
  end

  // Hold state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= XMBD_RST_MASK_START;
      taken_q  <= '0;
      pos_q    <= '0;
      top_q    <= '0;
      len_q    <= '0;
      off_q    <= '0;
      limit_q  <= XMBD_RST_DEC_LIMIT;
      inside_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      taken_q  <= taken_d;
      pos_q    <= pos_d;
      top_q    <= top_d;
      len_q    <= len_d;
      off_q    <= off_d;
      limit_q  <= limit_d;
      inside_q <= inside_d;
    end
  end

  // An open block always has a nonzero length and a valid offset
  a_block_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> (len_q != 16'd0) && (off_q < len_q))
    else $error("open block has bad length or offset");

  // The budget only shrinks until the next message restart
  a_limit_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !first_of_message_i) |=> (limit_q <= $past(limit_q)))
    else $error("decode budget grew within a message");

  // Without a transfer the decode state holds
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(taken_q) && $stable(mask_q) && $stable(inside_q))
    else $error("decode state moved without a transfer");

endmodule : xmbd_core

`default_nettype wire

FILE: sv/xmbd_skid.sv
// ----------------------------------------------------------------------------
// xmbd_skid: registered output stage with one skid entry
// Registers each result and takes one more into the skid entry while the
// receiver stalls, so the input stall comes from a flop, not out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module xmbd_skid
  import xmbd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire xmbd_result_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output xmbd_result_t      out_data_o
);

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  xmbd_result_t main_q, main_d;
  xmbd_result_t skid_q, skid_d;
  logic         in_xfer, out_xfer;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;
  assign out_xfer    = main_valid_q && !out_stall_i;

  // Refill the main entry from the skid entry first, then from the input
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || out_xfer) begin
      main_valid_d = skid_valid_q || in_xfer;
      main_d       = skid_valid_q ? skid_q : in_data_i;
      skid_valid_d = 1'b0;
    end else if (in_xfer) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // The skid entry is only in use behind a full main entry
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry filled while main entry empty");

  // A stalled full main entry catches the next input in the skid entry
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_valid_q && in_valid_i && main_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("stalled transfer not caught in skid entry");

  // A drained stage with no input goes empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && !out_stall_i && !skid_valid_q && !in_valid_i) |=> !main_valid_q)
    else $error("output stage did not drain");

endmodule : xmbd_skid

`default_nettype wire

FILE: sv/xor_mask_block_deinterleave.sv
// ----------------------------------------------------------------------------
// xor_mask_block_deinterleave: byte-serial XOR-mask block deinterleaver
// Takes ciphertext bytes in arrival order and returns each plaintext byte
// with its offset in the plaintext message.
//
// Input channel: in_valid_i / in_stall_o carry cipher_byte_i and
// first_of_message_i; a byte transfers when valid is high and stall low.
// first_of_message_i restarts the counters, the mask and the block budget.
// Output channel: out_valid_o / out_stall_i carry plain_byte_o,
// byte_position_o and last_of_message_o, one result per input byte.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 mask start, 1 mask increment, 2 block size, 3 decode limit,
// 4 message length); other indexes are ignored. Write only while idle.
// Output: each result is registered before it reaches the output ports.
// Throughput: one byte per cycle while in_stall_o is low, as the decode
// loop is unpipelined and a two-entry output stage takes bytes on stalls.
// Stall: once both output entries are full, in_stall_o rises from a flop.
// Reset: registers return to their defaults and the output stage empties.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_mask_block_deinterleave
  import xmbd_pkg::*;
#(
  parameter int unsigned PosW = XMBD_POS_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [XMBD_IDX_W-1:0]     cfg_index_i,
  input  wire logic [XMBD_CFG_W-1:0]     cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                cipher_byte_i,
  input  wire logic                      first_of_message_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [7:0]                     plain_byte_o,
  output logic [XMBD_OUT_POS_W-1:0]      byte_position_o,
  output logic                           last_of_message_o
);

  xmbd_cfg_t    cfg_q, cfg_d;
  xmbd_result_t core_res, out_res;
  logic         in_xfer;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        XMBD_REG_MASK_START: cfg_d.mask_start     = cfg_data_i[7:0];
        XMBD_REG_MASK_INC:   cfg_d.mask_increment = cfg_data_i[7:0];
        XMBD_REG_BLOCK_SIZE: cfg_d.block_size     = cfg_data_i[15:0];
        XMBD_REG_DEC_LIMIT:  cfg_d.decode_limit   = cfg_data_i;
        XMBD_REG_MSG_LEN:    cfg_d.message_length = cfg_data_i;
        default:             cfg_d                = cfg_q;
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_start     <= XMBD_RST_MASK_START;
      cfg_q.mask_increment <= XMBD_RST_MASK_INC;
      cfg_q.block_size     <= XMBD_RST_BLOCK_SIZE;
      cfg_q.decode_limit   <= XMBD_RST_DEC_LIMIT;
      cfg_q.message_length <= XMBD_RST_MSG_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  // Decode state and per-byte result
  xmbd_core #(
    .PosW (PosW)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .accept_i           (in_xfer),
    .cipher_byte_i      (cipher_byte_i),
    .first_of_message_i (first_of_message_i),
    .result_o           (core_res)
  );

  // Registered output with skid entry
  xmbd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (core_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign plain_byte_o      = out_res.plain_byte;
  assign byte_position_o   = out_res.byte_position;
  assign last_of_message_o = out_res.last_of_message;

endmodule : xor_mask_block_deinterleave

`default_nettype wire
